@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file elmc_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ELMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every clock edge, reset included.
`define ELMC_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/elmc_pkg.sv @@
// ----------------------------------------------------------------------------
// elmc_pkg
// Types and constants of the emergency light mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package elmc_pkg;

  localparam int unsigned TICKS_PER_SECOND   = 1000;
  localparam int unsigned SECONDS_PER_MINUTE = 60;
  localparam int unsigned TICKS_PER_MINUTE   = TICKS_PER_SECOND * SECONDS_PER_MINUTE;
  localparam int unsigned SETTLE_TICKS       = TICKS_PER_SECOND / 8;

  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned SETTLE_W = 10;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;

  // kind codes
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ON     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OFF    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT    = 2'd3;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_OFF           = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT_MAINS_OFF = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MANUAL        = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AUTO          = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WAIT_ON       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_WAIT_ON_UV    = 3'd5;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_AUTO_MIN   = 8'd5;
  localparam logic [BYTE_W-1:0] RST_MANUAL_MIN = 8'd30;
  localparam logic [BYTE_W-1:0] RST_DARK       = 8'd40;
  localparam logic [BYTE_W-1:0] RST_LOCKOUT    = 8'd10;

  typedef struct packed {
    logic [COUNT_W-1:0] auto_ticks;
    logic [COUNT_W-1:0] manual_ticks;
    logic [COUNT_W-1:0] lockout_ticks;
    logic [BYTE_W-1:0]  dark_threshold;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              button_pressed;
    logic              mains_on;
    logic              primary_mode;
    logic              photo_valid;
    logic [BYTE_W-1:0] average_light;
    logic [BYTE_W-1:0] current_light;
    logic              motion;
    logic              switch_undervolt;
    logic [BYTE_W-1:0] off_lockout;
  } item_t;

  typedef struct packed {
    logic              lamp_on;
    logic [MODE_W-1:0] mode_code;
    logic              clear_stats;
  } res_t;

  function automatic logic [COUNT_W-1:0] minutes_to_ticks(input logic [BYTE_W-1:0] mins);
    logic [31:0] prod;
    prod = 32'(mins) * 32'(TICKS_PER_MINUTE);
    return prod[COUNT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] seconds_to_ticks(input logic [BYTE_W-1:0] secs);
    logic [31:0] prod;
    prod = 32'(secs) * 32'(TICKS_PER_SECOND);
    return prod[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/elmc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// elmc_cfg_regs
// Configuration registers; periods are held pre-scaled to ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module elmc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [elmc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [elmc_pkg::BYTE_W-1:0]    cfg_wdata_i,
  output elmc_pkg::cfg_t                      cfg_o
);
  import elmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AUTO_MIN:   cfg_d.auto_ticks     = minutes_to_ticks(cfg_wdata_i);
        REG_MANUAL_MIN: cfg_d.manual_ticks   = minutes_to_ticks(cfg_wdata_i);
        REG_DARK:       cfg_d.dark_threshold = cfg_wdata_i;
        REG_LOCKOUT:    cfg_d.lockout_ticks  = seconds_to_ticks(cfg_wdata_i);
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_ticks     <= minutes_to_ticks(RST_AUTO_MIN);
      cfg_q.manual_ticks   <= minutes_to_ticks(RST_MANUAL_MIN);
      cfg_q.lockout_ticks  <= seconds_to_ticks(RST_LOCKOUT);
      cfg_q.dark_threshold <= RST_DARK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/elmc_mode_core.sv @@
// ----------------------------------------------------------------------------
// elmc_mode_core
// Lamp mode state machine, edge detectors and timers; one item per enable.
// ----------------------------------------------------------------------------
`default_nettype none

module elmc_mode_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire elmc_pkg::item_t item_i,
  input  wire elmc_pkg::cfg_t  cfg_i,
  output elmc_pkg::res_t       res_o
);
  import elmc_pkg::*;

  logic [MODE_W-1:0]   mode_q, mode_d;
  logic                button_q, button_d;
  logic                mains_q, mains_d;
  logic                lamp_q, lamp_d;
  logic [COUNT_W-1:0]  onoff_q, onoff_d;
  logic [SETTLE_W-1:0] settle_q, settle_d;
  logic [BYTE_W-1:0]   saved_q, saved_d;

  logic                clear;
  logic                pressed, came_on, went_off, settled, dark_ok;
  logic [COUNT_W-1:0]  onoff_dec, off_lock_ticks;
  logic [SETTLE_W-1:0] settle_dec;
  logic [BYTE_W-1:0]   lower;
  logic [BYTE_W:0]     upper;

  assign pressed    = item_i.button_pressed & ~button_q;
  assign came_on    = item_i.mains_on & ~mains_q;
  assign went_off   = ~item_i.mains_on & mains_q;
  assign onoff_dec  = (onoff_q == '0) ? '0 : onoff_q - COUNT_W'(1);
  assign settle_dec = (settle_q == '0) ? '0 : settle_q - SETTLE_W'(1);
  assign settled    = (settle_dec == '0);
  assign lower      = saved_q - (saved_q >> 2);
  assign upper      = {1'b0, saved_q} + {3'b000, saved_q[BYTE_W-1:2]};
  assign off_lock_ticks = seconds_to_ticks(item_i.off_lockout);
  assign dark_ok    = (~item_i.mains_on | item_i.primary_mode) & item_i.photo_valid &
                      (item_i.average_light <= cfg_i.dark_threshold) & item_i.motion &
                      (onoff_dec == '0);

  always_comb begin
    mode_d   = mode_q;
    button_d = button_q;
    mains_d  = mains_q;
    lamp_d   = lamp_q;
    onoff_d  = onoff_q;
    settle_d = settle_q;
    saved_d  = saved_q;
    clear    = 1'b0;

    unique case (item_i.kind)
      KIND_ON: begin
        onoff_d = cfg_i.manual_ticks;
        lamp_d  = 1'b1;
        mode_d  = MODE_MANUAL;
      end
      KIND_OFF: begin
        onoff_d = off_lock_ticks;
        lamp_d  = 1'b0;
        mode_d  = MODE_OFF;
      end
      KIND_TICK: begin
        button_d = item_i.button_pressed;
        mains_d  = item_i.mains_on;
        onoff_d  = onoff_dec;
        settle_d = settle_dec;
        unique case (mode_q)
          MODE_WAIT_MAINS_OFF: begin
            if (settled) begin
              if (item_i.current_light < lower) begin
                onoff_d = cfg_i.auto_ticks;
                lamp_d  = 1'b1;
                mode_d  = MODE_AUTO;
              end else begin
                mode_d = MODE_OFF;
              end
            end
          end
          MODE_MANUAL: begin
            priority if (pressed) begin
              onoff_d = cfg_i.lockout_ticks;
              lamp_d  = 1'b0;
              mode_d  = MODE_OFF;
            end else if (onoff_dec == '0) begin
              lamp_d = 1'b0;
              mode_d = MODE_OFF;
            end
          end
          MODE_AUTO: begin
            priority if (pressed) begin
              onoff_d = cfg_i.lockout_ticks;
              lamp_d  = 1'b0;
              mode_d  = MODE_OFF;
            end else if (came_on) begin
              saved_d  = item_i.average_light;
              settle_d = SETTLE_W'(SETTLE_TICKS);
              clear    = 1'b1;
              lamp_d   = 1'b0;
              mode_d   = item_i.switch_undervolt ? MODE_WAIT_ON_UV : MODE_WAIT_ON;
            end else if (item_i.motion) begin
              onoff_d = cfg_i.auto_ticks;
            end else if (onoff_dec == '0) begin
              lamp_d = 1'b0;
              mode_d = MODE_OFF;
            end
          end
          MODE_WAIT_ON, MODE_WAIT_ON_UV: begin
            if (settled) begin
              if ((mode_q == MODE_WAIT_ON) ? (item_i.current_light < lower)
                                           : ({1'b0, item_i.current_light} <= upper)) begin
                onoff_d = cfg_i.auto_ticks;
                lamp_d  = 1'b1;
                mode_d  = MODE_AUTO;
              end else begin
                onoff_d = '0;
                lamp_d  = 1'b0;
                mode_d  = MODE_OFF;
              end
            end
          end
          default: begin
            priority if (pressed) begin
              onoff_d = cfg_i.manual_ticks;
              lamp_d  = 1'b1;
              mode_d  = MODE_MANUAL;
            end else if (went_off) begin
              saved_d  = item_i.average_light;
              settle_d = SETTLE_W'(SETTLE_TICKS);
              clear    = 1'b1;
              mode_d   = MODE_WAIT_MAINS_OFF;
            end else if (dark_ok) begin
              onoff_d = cfg_i.auto_ticks;
              lamp_d  = 1'b1;
              mode_d  = MODE_AUTO;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      button_q <= 1'b0;
      mains_q  <= 1'b0;
      lamp_q   <= 1'b0;
      onoff_q  <= '0;
      settle_q <= '0;
      saved_q  <= '0;
    end else if (en_i) begin
      mode_q   <= mode_d;
      button_q <= button_d;
      mains_q  <= mains_d;
      lamp_q   <= lamp_d;
      onoff_q  <= onoff_d;
      settle_q <= settle_d;
      saved_q  <= saved_d;
    end
  end

  assign res_o.lamp_on     = lamp_d;
  assign res_o.mode_code   = mode_d;
  assign res_o.clear_stats = clear;

endmodule

`default_nettype wire

@@ rtl/core/emergency_light_mode_controller.sv @@
// ----------------------------------------------------------------------------
// emergency_light_mode_controller
// Lamp mode controller for a lighting UPS: input register, mode logic,
// result register.
//
//   channel   dir  handshake          payload
//   s_axis    in   tvalid/tready      tuser: kind; tdata: tick fields
//   m_axis    out  tvalid/tready      tdata: lamp_on, mode_code, clear_stats
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained unless the output stalls; each item passes once
// through elmc_mode_core between the input and result registers.
// Reset clears mode, edge history, timers and both valid flags.
// A stalled output holds its result; the input register keeps taking items
// while the output register can move on in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module emergency_light_mode_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // button_pressed, mains_on, primary_mode, photo_valid, average_light[7:0],
  // current_light[7:0], motion, switch_undervolt, off_lockout[7:0], zero pad
  input  wire logic [elmc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  wire logic [elmc_pkg::KIND_W-1:0]     s_axis_tuser,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // lamp_on, mode_code[2:0], clear_stats, zero pad
  output      logic [elmc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                            cfg_we_i,
  input  wire logic [elmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [elmc_pkg::BYTE_W-1:0]     cfg_wdata_i
);
  import elmc_pkg::*;

  cfg_t  cfg;
  item_t item_d, item_q;
  res_t  res, res_q;
  logic  in_valid_q, out_valid_q, advance;

  assign item_d.kind             = s_axis_tuser;
  assign item_d.button_pressed   = s_axis_tdata[0];
  assign item_d.mains_on         = s_axis_tdata[1];
  assign item_d.primary_mode     = s_axis_tdata[2];
  assign item_d.photo_valid      = s_axis_tdata[3];
  assign item_d.average_light    = s_axis_tdata[11:4];
  assign item_d.current_light    = s_axis_tdata[19:12];
  assign item_d.motion           = s_axis_tdata[20];
  assign item_d.switch_undervolt = s_axis_tdata[21];
  assign item_d.off_lockout      = s_axis_tdata[29:22];

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  elmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  elmc_mode_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.clear_stats, res_q.mode_code, res_q.lamp_on};

endmodule

`default_nettype wire

@@ rtl/core/elmc_checker.sv @@
// ----------------------------------------------------------------------------
// elmc_checker
// Port-level checks on the lamp controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module elmc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [elmc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [elmc_pkg::KIND_W-1:0]     s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [elmc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                            cfg_we_i,
  input wire logic [elmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input wire logic [elmc_pkg::BYTE_W-1:0]     cfg_wdata_i
);
  import elmc_pkg::*;

  logic [MODE_W-1:0] mode_code;
  logic              lamp_on, clear_stats, unused;

  assign lamp_on     = m_axis_tdata[0];
  assign mode_code   = m_axis_tdata[3:1];
  assign clear_stats = m_axis_tdata[4];
  assign unused      = ^{s_axis_tvalid, s_axis_tready, s_axis_tdata, s_axis_tuser,
                         cfg_we_i, cfg_idx_i, cfg_wdata_i};

  // held result while stalled
  `ELMC_ASSERT_IMPLY(a_hold, clk_i, rst_ni, $past(m_axis_tvalid && !m_axis_tready) && $past(rst_ni), $stable(m_axis_tdata))
  // nothing offered straight after reset
  `ELMC_ASSERT_NEXT(a_rst_idle, clk_i, !rst_ni, !m_axis_tvalid)
  // lamp lit exactly in manual or automatic mode
  `ELMC_ASSERT_IMPLY(a_lamp_mode, clk_i, rst_ni, m_axis_tvalid, lamp_on == (mode_code == MODE_MANUAL || mode_code == MODE_AUTO))
  // statistics cleared only on entry to a mains wait
  `ELMC_ASSERT_IMPLY(a_clear_wait, clk_i, rst_ni, m_axis_tvalid && clear_stats, mode_code == MODE_WAIT_MAINS_OFF || mode_code == MODE_WAIT_ON || mode_code == MODE_WAIT_ON_UV)

endmodule

bind emergency_light_mode_controller elmc_checker u_elmc_checker (.*);

`default_nettype wire

@@ bench/tb_emergency_light_mode_controller.sv @@
// ----------------------------------------------------------------------------
// tb_emergency_light_mode_controller
// Self-checking bench for the lamp mode controller. A queue of control items
// (directed cases, mains-off and mains-on settle runs, a full lockout run and
// random noise) feeds a stream driver; a local lamp-mode predictor computes
// each expected result on input transfer and the monitor checks every output
// transfer against the oldest expectation. Registers are rewritten between
// phases once the block has drained; both sides stall at random outside the calm phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_emergency_light_mode_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import elmc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
  localparam int                STALL_LIMIT = 2000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [BYTE_W-1:0]     cfg_wdata_i   = '0;

  emergency_light_mode_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t ctrl_item_q[$];
  res_t  lamp_expect_q[$];
  item_t drive_item;
  res_t  want;
  int    n_mismatch  = 0;
  int    idle_cycles = 0;
  bit    calm        = 1'b0;
  logic  noise_mains = 1'b0;

  // register shadows
  logic [BYTE_W-1:0] cfg_auto_min;
  logic [BYTE_W-1:0] cfg_manual_min;
  logic [BYTE_W-1:0] cfg_dark;
  logic [BYTE_W-1:0] cfg_lockout;

  // predicted controller state
  logic [MODE_W-1:0]   lm_mode       = MODE_OFF;
  logic                lm_btn_prev   = 1'b0;
  logic                lm_mains_prev = 1'b0;
  logic                lm_lamp       = 1'b0;
  logic [COUNT_W-1:0]  lm_onoff      = '0;
  logic [SETTLE_W-1:0] lm_settle     = '0;
  logic [BYTE_W-1:0]   lm_saved      = '0;

  function automatic void load_on_timer(input logic [BYTE_W-1:0] mins);
    lm_onoff = 24'(32'(mins) * TICKS_PER_MINUTE);
  endfunction

  function automatic void enter_auto();
    load_on_timer(cfg_auto_min);
    lm_lamp = 1'b1;
    lm_mode = MODE_AUTO;
  endfunction

  function automatic void enter_manual();
    load_on_timer(cfg_manual_min);
    lm_lamp = 1'b1;
    lm_mode = MODE_MANUAL;
  endfunction

  function automatic void enter_off(input logic [BYTE_W-1:0] secs);
    lm_onoff = (secs != 0) ? 24'(32'(secs) * TICKS_PER_SECOND) : '0;
    lm_lamp  = 1'b0;
    lm_mode  = MODE_OFF;
  endfunction

  function automatic void start_settle(input logic [BYTE_W-1:0] avg);
    lm_saved  = avg;
    lm_settle = SETTLE_W'(SETTLE_TICKS);
  endfunction

  function automatic res_t next_lamp_result(input item_t it);
    res_t r;
    logic pressed, came_on, went_off;
    int   lower, upper;
    r = '0;
    if (it.kind == KIND_ON) begin
      enter_manual();
    end else if (it.kind == KIND_OFF) begin
      enter_off(it.off_lockout);
    end else if (it.kind == KIND_TICK) begin
      pressed  = it.button_pressed && !lm_btn_prev;
      came_on  = it.mains_on && !lm_mains_prev;
      went_off = !it.mains_on && lm_mains_prev;
      lower    = int'(lm_saved) - int'(lm_saved >> 2);
      upper    = int'(lm_saved) + int'(lm_saved >> 2);
      lm_btn_prev   = it.button_pressed;
      lm_mains_prev = it.mains_on;
      if (lm_onoff != 0) lm_onoff = lm_onoff - 1'b1;
      if (lm_settle != 0) lm_settle = lm_settle - 1'b1;
      case (lm_mode)
        MODE_WAIT_MAINS_OFF: begin
          if (lm_settle == 0) begin
            if (int'(it.current_light) < lower) enter_auto();
            else lm_mode = MODE_OFF;
          end
        end
        MODE_MANUAL: begin
          if (pressed) enter_off(cfg_lockout);
          else if (lm_onoff == 0) enter_off('0);
        end
        MODE_AUTO: begin
          if (pressed) begin
            enter_off(cfg_lockout);
          end else if (came_on) begin
            start_settle(it.average_light);
            r.clear_stats = 1'b1;
            lm_lamp = 1'b0;
            lm_mode = it.switch_undervolt ? MODE_WAIT_ON_UV : MODE_WAIT_ON;
          end else if (it.motion) begin
            load_on_timer(cfg_auto_min);
          end else if (lm_onoff == 0) begin
            enter_off('0);
          end
        end
        MODE_WAIT_ON: begin
          if (lm_settle == 0) begin
            if (int'(it.current_light) < lower) enter_auto();
            else enter_off('0);
          end
        end
        MODE_WAIT_ON_UV: begin
          if (lm_settle == 0) begin
            if (int'(it.current_light) <= upper) enter_auto();
            else enter_off('0);
          end
        end
        default: begin
          if (pressed) begin
            enter_manual();
          end else if (went_off) begin
            start_settle(it.average_light);
            r.clear_stats = 1'b1;
            lm_mode = MODE_WAIT_MAINS_OFF;
          end else if ((!it.mains_on || it.primary_mode) && it.photo_valid &&
                       it.average_light <= cfg_dark && it.motion && lm_onoff == 0) begin
            enter_auto();
          end
        end
      endcase
    end
    r.lamp_on   = lm_lamp;
    r.mode_code = lm_mode;
    return r;
  endfunction

  // ---- stimulus helpers ----

  function automatic item_t any_tick();
    item_t it;
    it = item_t'($urandom);
    it.kind = KIND_TICK;
    return it;
  endfunction

  task automatic push_tick(input logic b, m, p, v, input logic [7:0] avg, cur,
                           input logic mot, uv);
    item_t it;
    it = any_tick();
    it.button_pressed   = b;
    it.mains_on         = m;
    it.primary_mode     = p;
    it.photo_valid      = v;
    it.average_light    = avg;
    it.current_light    = cur;
    it.motion           = mot;
    it.switch_undervolt = uv;
    ctrl_item_q.push_back(it);
  endtask

  task automatic push_cmd(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] secs);
    item_t it;
    it = item_t'($urandom);
    it.kind        = k;
    it.off_lockout = secs;
    ctrl_item_q.push_back(it);
  endtask

  // settle filler, then the deciding tick with current light at or just past its limit, or left random
  task automatic add_settle_tail(input logic [BYTE_W-1:0] saved, input logic uv_rule);
    item_t it;
    int    bound;
    repeat (SETTLE_TICKS - 1) ctrl_item_q.push_back(any_tick());
    if (uv_rule) bound = int'(saved) + int'(saved >> 2);
    else bound = int'(saved) - int'(saved >> 2) - 1;
    it = any_tick();
    case ($urandom_range(2))
      0: it.current_light = 8'((bound < 0) ? 0 : (bound > 255) ? 255 : bound);
      1: it.current_light = 8'((bound + 1 > 255) ? 255 : bound + 1);
      default: ;
    endcase
    ctrl_item_q.push_back(it);
    repeat (2) ctrl_item_q.push_back(any_tick());
  endtask

  task automatic add_mains_off_run();
    item_t it;
    push_cmd(KIND_OFF, '0);
    it = any_tick();
    it.button_pressed = 1'b0;
    it.mains_on       = 1'b1;
    it.motion         = 1'b0;
    ctrl_item_q.push_back(it);
    it = any_tick();
    it.button_pressed = 1'b0;
    it.mains_on       = 1'b0;
    ctrl_item_q.push_back(it);
    add_settle_tail(it.average_light, 1'b0);
  endtask

  task automatic add_mains_on_run(input logic uv);
    item_t it;
    push_cmd(KIND_OFF, '0);
    it = any_tick();
    it.button_pressed = 1'b0;
    it.mains_on       = 1'b1;
    it.primary_mode   = 1'b1;
    it.photo_valid    = 1'b1;
    it.average_light  = 8'($urandom_range(cfg_dark));
    it.motion         = 1'b1;
    ctrl_item_q.push_back(it);
    it = any_tick();
    it.button_pressed = 1'b0;
    it.mains_on       = 1'b0;
    it.motion         = 1'b1;
    ctrl_item_q.push_back(it);
    it = any_tick();
    it.button_pressed   = 1'b0;
    it.mains_on         = 1'b1;
    it.switch_undervolt = uv;
    ctrl_item_q.push_back(it);
    add_settle_tail(it.average_light, uv);
  endtask

  // one-second lockout holding off the dark-and-motion auto entry until it runs out
  task automatic add_lockout_run();
    item_t it;
    push_cmd(KIND_ON, '0);
    it = any_tick();
    it.button_pressed = 1'b0;
    it.mains_on       = 1'b0;
    ctrl_item_q.push_back(it);
    push_cmd(KIND_OFF, 8'd1);
    repeat (TICKS_PER_SECOND + 2) begin
      it = any_tick();
      it.button_pressed = 1'b0;
      it.mains_on       = 1'b0;
      it.photo_valid    = 1'b1;
      it.average_light  = 8'($urandom_range(cfg_dark));
      it.motion         = 1'b1;
      ctrl_item_q.push_back(it);
    end
  endtask

  task automatic add_noise(input int n);
    item_t it;
    repeat (n) begin
      it = item_t'($urandom);
      if ($urandom_range(99) < 75) it.kind = KIND_TICK;
      if ($urandom_range(19) == 0) noise_mains = !noise_mains;
      it.mains_on = noise_mains;
      if ($urandom_range(1) != 0) it.average_light = cfg_dark + 8'($urandom_range(2)) - 8'd1;
      ctrl_item_q.push_back(it);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_AUTO_MIN:   cfg_auto_min   = val;
      REG_MANUAL_MIN: cfg_manual_min = val;
      REG_DARK:       cfg_dark       = val;
      default:        cfg_lockout    = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [BYTE_W-1:0] a, m, d, l);
    write_reg(REG_AUTO_MIN, a);
    write_reg(REG_MANUAL_MIN, m);
    write_reg(REG_DARK, d);
    write_reg(REG_LOCKOUT, l);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic drain();
    while (ctrl_item_q.size() != 0 || s_axis_tvalid || lamp_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---- driver ----
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) lamp_expect_q.push_back(next_lamp_result(drive_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ctrl_item_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
          drive_item = ctrl_item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, drive_item.off_lockout, drive_item.switch_undervolt,
                            drive_item.motion, drive_item.current_light,
                            drive_item.average_light, drive_item.photo_valid,
                            drive_item.primary_mode, drive_item.mains_on,
                            drive_item.button_pressed};
          s_axis_tuser  <= drive_item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lamp_expect_q.size() == 0) begin
          if (n_mismatch < 10) $display("unexpected result transfer: %h", m_axis_tdata);
          n_mismatch++;
        end else begin
          want = lamp_expect_q.pop_front();
          if (m_axis_tdata[0] !== want.lamp_on || m_axis_tdata[3:1] !== want.mode_code ||
              m_axis_tdata[4] !== want.clear_stats) begin
            if (n_mismatch < 10)
              $display("mismatch: exp lamp %0d mode %0d clear %0d, got lamp %0d mode %0d clear %0d",
                       want.lamp_on, want.mode_code, want.clear_stats,
                       m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[4]);
            n_mismatch++;
          end
        end
      end
      m_axis_tready <= calm || $urandom_range(99) >= 12;
    end
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_auto_min   = RST_AUTO_MIN;
    cfg_manual_min = RST_MANUAL_MIN;
    cfg_dark       = RST_DARK;
    cfg_lockout    = RST_LOCKOUT;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset register values
    push_cmd(KIND_SPARE, '0);
    push_tick(0, 0, 0, 0, 8'd0, 8'd0, 0, 0);
    push_tick(1, 0, 0, 0, 8'd0, 8'd0, 0, 0);       // press: manual
    push_tick(1, 0, 0, 0, 8'd0, 8'd0, 0, 0);       // held, no edge
    push_tick(0, 0, 0, 0, 8'd0, 8'd0, 0, 0);
    push_tick(1, 0, 0, 0, 8'd0, 8'd0, 0, 0);       // press: off with lockout
    push_tick(0, 0, 0, 1, 8'd0, 8'd0, 1, 0);       // dark + motion, locked out
    push_cmd(KIND_OFF, '0);                         // cancel lockout
    push_tick(0, 0, 0, 1, 8'd40, 8'd0, 1, 0);      // avg at threshold: auto
    push_tick(0, 0, 0, 1, 8'd255, 8'd0, 1, 0);     // motion restarts on timer
    push_tick(0, 0, 0, 0, 8'd0, 8'd0, 0, 0);
    push_tick(1, 0, 0, 0, 8'd0, 8'd0, 0, 0);       // press in auto
    push_cmd(KIND_ON, '0);
    push_cmd(KIND_OFF, 8'd255);
    ctrl_item_q.push_back('1);                      // spare kind, all fields high
    push_cmd(KIND_OFF, '0);
    push_tick(0, 1, 1, 1, 8'd41, 8'd255, 1, 1);    // just above dark
    push_tick(0, 1, 0, 1, 8'd0, 8'd0, 1, 0);       // mains on, not primary
    push_tick(0, 1, 1, 0, 8'd0, 8'd0, 1, 0);       // no valid sample
    push_tick(0, 1, 1, 1, 8'd0, 8'd0, 0, 0);       // no motion
    push_tick(1, 1, 1, 1, 8'd255, 8'd255, 1, 1);
    push_cmd(KIND_ON, '0);
    push_cmd(KIND_OFF, '0);
    push_tick(0, 0, 1, 1, 8'd200, 8'd0, 0, 0);     // mains lost: wait, clear
    add_noise(60);
    add_mains_off_run();
    drain();

    set_regs(8'd0, 8'd0, 8'd0, 8'd0);
    add_mains_on_run(1'b0);
    add_mains_off_run();
    add_noise(60);
    drain();

    set_regs(8'd255, 8'd255, 8'd255, 8'd255);
    add_mains_on_run(1'b1);
    add_mains_off_run();
    add_noise(60);
    drain();

    set_regs(8'd1, 8'd2, 8'd128, 8'd0);
    calm = 1'b1;
    add_lockout_run();
    add_noise(40);
    drain();
    calm = 1'b0;

    set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    add_mains_on_run(1'($urandom_range(1)));
    add_noise(60);
    drain();

    if (n_mismatch == 0 && lamp_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/elmc_pkg.sv
rtl/core/elmc_cfg_regs.sv
rtl/core/elmc_mode_core.sv
rtl/core/emergency_light_mode_controller.sv
rtl/core/elmc_checker.sv
bench/tb_emergency_light_mode_controller.sv
